FILE: design/gdsd_pkg.sv
// Package for the Gregorian date shift and distance unit.
// Holds payload structs, controller and micro-op enums, calendar constants and tables.
// No dependencies.
package gdsd_pkg;

  // internal widths
  localparam int CNT_W = 23;            // linear day count from the biased epoch
  localparam int YB_W  = 14;            // biased year (year + bias)
  localparam int K_W   = 5;             // step counter inside one loop phase
  localparam int OCT_N = (CNT_W + 2) / 3;

  localparam logic [YB_W-1:0] YEAR_BIAS_YB = YB_W'(4000);
  localparam logic [YB_W-1:0] ERA_YEARS    = YB_W'(400);
  localparam logic [YB_W-1:0] CENT_YEARS   = YB_W'(100);
  localparam logic [YB_W-1:0] QUAD_YEARS   = YB_W'(4);
  localparam logic [YB_W-1:0] ONE_YEAR     = YB_W'(1);

  localparam logic [CNT_W-1:0] ERA_DAYS  = CNT_W'(146097);
  localparam logic [CNT_W-1:0] CENT_DAYS = CNT_W'(36524);
  localparam logic [CNT_W-1:0] QUAD_DAYS = CNT_W'(1461);
  localparam logic [CNT_W-1:0] YEAR_DAYS = CNT_W'(365);

  // loop limits (most steps a loop phase may take; the index must stay below it)
  localparam logic [K_W-1:0] CENT_MAX = K_W'(3);
  localparam logic [K_W-1:0] QUAD_MAX = K_W'(24);
  localparam logic [K_W-1:0] YR_MAX   = K_W'(3);
  localparam logic [K_W-1:0] MON_MAX  = K_W'(11);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [3:0] MAR_BASED_JAN = 4'd10;  // March-based index of January
  localparam logic [3:0] MAR_SHIFT_UP  = 4'd3;
  localparam logic [3:0] MAR_SHIFT_DN  = 4'd9;

  // day count zero (March 1, biased year 0) falls on a Wednesday
  localparam logic [3:0] WEEKDAY_BIAS = 4'd3;
  localparam logic [3:0] WEEK_DAYS    = 4'd7;

  localparam logic OP_SHIFT = 1'b0;
  localparam logic OP_DIST  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
    logic signed [19:0] offset;
    logic [4:0]         other_day;
    logic [3:0]         other_month;
    logic [11:0]        other_year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [11:0] result_year;
    logic [2:0]  weekday;
    logic [18:0] day_distance;
    logic        range_error;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_ERA, S_F_CENT, S_F_QUAD, S_F_YR, S_F_FIN, S_F_NEXT,
    S_I_START, S_I_ERA, S_I_CENT, S_I_QUAD, S_I_YR, S_I_MON, S_I_FIN, S_I_NEXT,
    S_DONE
  } state_t;

  typedef enum logic {
    PASS_A,
    PASS_B
  } pass_t;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_LOAD_IN,
    UOP_SWAP,
    UOP_F_ERA, UOP_F_CENT, UOP_F_QUAD, UOP_F_YR, UOP_F_FIN,
    UOP_I_START, UOP_I_ERA, UOP_I_CENT, UOP_I_QUAD, UOP_I_YR, UOP_I_MON, UOP_I_FIN,
    UOP_LOAD_OUT
  } uop_t;

  typedef struct packed {
    logic more;       // current loop phase takes another step
    logic op_dist;
    logic fvalid;     // date of last forward pass is valid
    logic range_ok;   // shifted year within range
    logic out_free;   // output register can take a result
  } dp_status_t;

  // offset of the first of a month from March 1 of the same calendar year;
  // January and February of a leap year need one day less
  function automatic logic signed [9:0] month_offset(input logic [3:0] m);
    logic signed [9:0] r;
    case (m)
      4'd1:    r = -10'sd59;
      4'd2:    r = -10'sd28;
      4'd3:    r = 10'sd0;
      4'd4:    r = 10'sd31;
      4'd5:    r = 10'sd61;
      4'd6:    r = 10'sd92;
      4'd7:    r = 10'sd122;
      4'd8:    r = 10'sd153;
      4'd9:    r = 10'sd184;
      4'd10:   r = 10'sd214;
      4'd11:   r = 10'sd245;
      4'd12:   r = 10'sd275;
      default: r = 10'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // month lengths from March on; February is never stepped over
  function automatic logic [4:0] mar_month_len(input logic [3:0] idx);
    logic [4:0] r;
    case (idx)
      4'd1, 4'd3, 4'd6, 4'd8: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

  // residue mod 7 by summing octal digits (8 == 1 mod 7)
  function automatic logic [2:0] mod7(input logic [CNT_W-1:0] x);
    logic [3*OCT_N-1:0] xe;
    logic [5:0]         s;
    logic [3:0]         t;
    xe = (3*OCT_N)'(x);
    s  = '0;
    for (int i = 0; i < OCT_N; i++) begin
      s = s + 6'(xe[3*i +: 3]);
    end
    t = 4'(s[2:0]) + 4'(s[5:3]);
    if (t >= 4'd14) begin
      t = t - 4'd14;
    end else if (t >= WEEK_DAYS) begin
      t = t - WEEK_DAYS;
    end
    return t[2:0];
  endfunction

endpackage

FILE: design/gdsd_chan_if.sv
// Valid/ready channel interface used for the item and result streams.
// The payload type is a parameter; no package dependency.
interface gdsd_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/gregorian_date_shift_and_distance.sv
// Gregorian date shift / distance unit, one item at a time.
// Processing time is set by the one-step-per-cycle day-count loops (eras, centuries,
// 4-year groups, years, months).
// One item in work at a time; next item is taken while the result waits in the out register.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
// Depends on gdsd_pkg, gdsd_chan_if, gdsd_ctrl, gdsd_dp.
module gregorian_date_shift_and_distance import gdsd_pkg::*; #(
  parameter int MIN_YEAR = 1400,
  parameter int MAX_YEAR = 2400
) (
  input logic          clk,
  input logic          rst_n,
  gdsd_chan_if.sink    in_chan,
  gdsd_chan_if.source  out_chan
);

  // Flow per transaction:
  //   distance: forward-convert second date -> save count -> forward-convert first date,
  //             distance = |c1 - c2|, weekday from c1.
  //   shift:    forward-convert date, add offset, inverse-convert, range check,
  //             forward-convert the new date again to get its weekday.
  // Forward conversion counts days to March 1 of the biased year by repeated
  // subtraction of 400/100/4/1 years, then adds the day within the year.
  // Leap year comes out of the 400- and 100-year remainders on the way.

  uop_t       uop;
  dp_status_t status;
  logic       in_ready;

  gdsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .uop      (uop)
  );

  gdsd_dp #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uop       (uop),
    .in_item   (in_chan.payload),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.payload),
    .out_valid (out_chan.valid),
    .status    (status)
  );

  assign in_chan.ready = in_ready;

`ifndef ASSERT_OFF
  // only one transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while previous transaction still in work");

  // result register is never overwritten while it holds an untaken result
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uop == UOP_LOAD_OUT) |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten before it was taken");

  // error results carry all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.payload.range_error) |->
      (out_chan.payload.result_day == '0 && out_chan.payload.result_month == '0 &&
       out_chan.payload.result_year == '0 && out_chan.payload.weekday == '0 &&
       out_chan.payload.day_distance == '0))
    else $error("error result with nonzero fields");
`endif

endmodule

FILE: design/gdsd_ctrl.sv
// Sequencer for the date unit: walks the forward and inverse day-count loops.
// Depends on gdsd_pkg; drives micro-ops into gdsd_dp.
module gdsd_ctrl import gdsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output uop_t       uop
);

  state_t state_r, state_nxt;
  pass_t  pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= PASS_A;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_F_ERA;
          pass_nxt  = PASS_A;
        end
      end
      S_F_ERA:  if (!status.more) state_nxt = S_F_CENT;
      S_F_CENT: if (!status.more) state_nxt = S_F_QUAD;
      S_F_QUAD: if (!status.more) state_nxt = S_F_YR;
      S_F_YR:   if (!status.more) state_nxt = S_F_FIN;
      S_F_FIN:  state_nxt = S_F_NEXT;
      S_F_NEXT: begin
        if (pass_r == PASS_A && status.op_dist) begin
          state_nxt = S_F_ERA;
          pass_nxt  = PASS_B;
        end else if (pass_r == PASS_A && status.fvalid && !status.op_dist) begin
          state_nxt = S_I_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_I_START: state_nxt = S_I_ERA;
      S_I_ERA:   if (!status.more) state_nxt = S_I_CENT;
      S_I_CENT:  if (!status.more) state_nxt = S_I_QUAD;
      S_I_QUAD:  if (!status.more) state_nxt = S_I_YR;
      S_I_YR:    if (!status.more) state_nxt = S_I_MON;
      S_I_MON:   if (!status.more) state_nxt = S_I_FIN;
      S_I_FIN:   state_nxt = S_I_NEXT;
      S_I_NEXT: begin
        if (status.range_ok) begin
          state_nxt = S_F_ERA;
          pass_nxt  = PASS_B;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    uop      = UOP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        uop      = in_valid ? UOP_LOAD_IN : UOP_NONE;
      end
      S_F_ERA:   uop = UOP_F_ERA;
      S_F_CENT:  uop = UOP_F_CENT;
      S_F_QUAD:  uop = UOP_F_QUAD;
      S_F_YR:    uop = UOP_F_YR;
      S_F_FIN:   uop = UOP_F_FIN;
      S_F_NEXT:  uop = (pass_r == PASS_A && status.op_dist) ? UOP_SWAP : UOP_NONE;
      S_I_START: uop = UOP_I_START;
      S_I_ERA:   uop = UOP_I_ERA;
      S_I_CENT:  uop = UOP_I_CENT;
      S_I_QUAD:  uop = UOP_I_QUAD;
      S_I_YR:    uop = UOP_I_YR;
      S_I_MON:   uop = UOP_I_MON;
      S_I_FIN:   uop = UOP_I_FIN;
      S_I_NEXT:  uop = UOP_NONE;
      S_DONE:    uop = status.out_free ? UOP_LOAD_OUT : UOP_NONE;
      default:   uop = UOP_NONE;
    endcase
  end

endmodule

FILE: design/gdsd_dp.sv
// Datapath of the date unit: day-count accumulator, year remainder, date registers,
// output register. Depends on gdsd_pkg; sequenced by gdsd_ctrl.
module gdsd_dp import gdsd_pkg::*; #(
  parameter int MIN_YEAR = 1400,
  parameter int MAX_YEAR = 2400
) (
  input  logic       clk,
  input  logic       rst_n,
  input  uop_t       uop,
  input  in_item_t   in_item,
  input  logic       out_ready,
  output out_item_t  out_item,
  output logic       out_valid,
  output dp_status_t status
);

  localparam logic [YB_W-1:0] MIN_Y  = YB_W'(MIN_YEAR);
  localparam logic [YB_W-1:0] MAX_Y  = YB_W'(MAX_YEAR);
  localparam logic [YB_W-1:0] MIN_YB = YB_W'(MIN_YEAR + 4000);
  localparam logic [YB_W-1:0] MAX_YB = YB_W'(MAX_YEAR + 4000);

  logic               op_r, op_nxt;
  logic [4:0]         d1_r, d1_nxt;
  logic [3:0]         m1_r, m1_nxt;
  logic [11:0]        y1_r, y1_nxt;
  logic signed [19:0] off_r, off_nxt;
  logic [4:0]         fd_r, fd_nxt;        // current date
  logic [3:0]         fm_r, fm_nxt;
  logic [YB_W-1:0]    ydate_r, ydate_nxt;  // biased year, also year accumulator
  logic [YB_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic               r400z_r, r400z_nxt;
  logic               leap_r, leap_nxt;
  logic               yok_r, yok_nxt;
  logic               fvalid_r, fvalid_nxt;
  logic [CNT_W-1:0]   c2_r, c2_nxt;
  logic               ok2_r, ok2_nxt;
  logic               range_ok_r, range_ok_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [11:0]        sel_year;
  logic [YB_W-1:0]    sel_yb;
  logic               sel_yok;
  logic signed [10:0] fin_adj;
  logic [4:0]         mdays;
  logic [3:0]         mp;
  logic [3:0]         mm;
  logic [YB_W-1:0]    yb_fin;
  logic               err;
  logic [CNT_W-1:0]   diff;
  logic [3:0]         wd_sum;
  logic [YB_W-1:0]    yout;
  logic               more;

  assign sel_year = (uop == UOP_LOAD_IN)
                    ? (in_item.operation ? in_item.other_year : in_item.year) : y1_r;
  assign sel_yb   = YB_W'(sel_year) + YEAR_BIAS_YB;
  assign sel_yok  = (YB_W'(sel_year) >= MIN_Y) && (YB_W'(sel_year) <= MAX_Y);

  assign fin_adj = 11'(month_offset(fm_r)) + $signed({6'b0, fd_r}) - 11'sd1
                   - $signed({10'b0, (fm_r <= MONTH_FEB) && leap_r});
  assign mdays   = month_days(fm_r, leap_r);

  assign mp     = k_r[3:0];
  assign mm     = (mp < MAR_BASED_JAN) ? mp + MAR_SHIFT_UP : mp - MAR_SHIFT_DN;
  assign yb_fin = ydate_r + ((mm <= MONTH_FEB) ? ONE_YEAR : '0);

  assign err  = (op_r == OP_DIST) ? !(fvalid_r && ok2_r) : !(fvalid_r && range_ok_r);
  assign diff = (acc_r >= c2_r) ? acc_r - c2_r : c2_r - acc_r;
  assign yout = ydate_r - YEAR_BIAS_YB;

  always_comb begin
    wd_sum = {1'b0, mod7(acc_r)} + WEEKDAY_BIAS;
    if (wd_sum >= WEEK_DAYS) begin
      wd_sum = wd_sum - WEEK_DAYS;
    end
  end

  always_comb begin
    op_nxt        = op_r;
    d1_nxt        = d1_r;
    m1_nxt        = m1_r;
    y1_nxt        = y1_r;
    off_nxt       = off_r;
    fd_nxt        = fd_r;
    fm_nxt        = fm_r;
    ydate_nxt     = ydate_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    r400z_nxt     = r400z_r;
    leap_nxt      = leap_r;
    yok_nxt       = yok_r;
    fvalid_nxt    = fvalid_r;
    c2_nxt        = c2_r;
    ok2_nxt       = ok2_r;
    range_ok_nxt  = range_ok_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    more          = 1'b0;

    unique case (uop)
      UOP_LOAD_IN: begin
        op_nxt    = in_item.operation;
        d1_nxt    = in_item.day;
        m1_nxt    = in_item.month;
        y1_nxt    = in_item.year;
        off_nxt   = in_item.offset;
        // distance converts the second date first
        fd_nxt    = in_item.operation ? in_item.other_day : in_item.day;
        fm_nxt    = in_item.operation ? in_item.other_month : in_item.month;
        ydate_nxt = sel_yb;
        rem_nxt   = sel_yb;
        yok_nxt   = sel_yok;
        acc_nxt   = '0;
        k_nxt     = '0;
      end
      UOP_SWAP: begin
        c2_nxt    = acc_r;
        ok2_nxt   = fvalid_r;
        fd_nxt    = d1_r;
        fm_nxt    = m1_r;
        ydate_nxt = sel_yb;
        rem_nxt   = sel_yb;
        yok_nxt   = sel_yok;
        acc_nxt   = '0;
      end
      // forward: days up to March 1 of the biased year, then the day of year
      UOP_F_ERA: begin
        more = rem_r >= ERA_YEARS;
        if (more) begin
          rem_nxt = rem_r - ERA_YEARS;
          acc_nxt = acc_r + ERA_DAYS;
        end else begin
          r400z_nxt = (rem_r == '0);
        end
      end
      UOP_F_CENT: begin
        more = rem_r >= CENT_YEARS;
        if (more) begin
          rem_nxt = rem_r - CENT_YEARS;
          acc_nxt = acc_r + CENT_DAYS;
        end else begin
          leap_nxt = ((rem_r[1:0] == 2'b00) && (rem_r != '0)) || r400z_r;
        end
      end
      UOP_F_QUAD: begin
        more = rem_r >= QUAD_YEARS;
        if (more) begin
          rem_nxt = rem_r - QUAD_YEARS;
          acc_nxt = acc_r + QUAD_DAYS;
        end
      end
      UOP_F_YR: begin
        more = rem_r != '0;
        if (more) begin
          rem_nxt = rem_r - ONE_YEAR;
          acc_nxt = acc_r + YEAR_DAYS;
        end
      end
      UOP_F_FIN: begin
        acc_nxt    = acc_r + CNT_W'(fin_adj);
        fvalid_nxt = yok_r && (fm_r >= MONTH_JAN) && (fm_r <= MONTH_DEC)
                     && (fd_r != '0) && (fd_r <= mdays);
      end
      // inverse: peel eras, centuries, 4-year groups, years, months
      UOP_I_START: begin
        acc_nxt   = acc_r + CNT_W'(off_r);
        ydate_nxt = '0;
        k_nxt     = '0;
      end
      UOP_I_ERA: begin
        more = acc_r >= ERA_DAYS;
        if (more) begin
          acc_nxt   = acc_r - ERA_DAYS;
          ydate_nxt = ydate_r + ERA_YEARS;
        end
      end
      UOP_I_CENT: begin
        more = (k_r < CENT_MAX) && (acc_r >= CENT_DAYS);
        if (more) begin
          acc_nxt   = acc_r - CENT_DAYS;
          ydate_nxt = ydate_r + CENT_YEARS;
          k_nxt     = k_r + K_W'(1);
        end else begin
          k_nxt = '0;
        end
      end
      UOP_I_QUAD: begin
        more = (k_r < QUAD_MAX) && (acc_r >= QUAD_DAYS);
        if (more) begin
          acc_nxt   = acc_r - QUAD_DAYS;
          ydate_nxt = ydate_r + QUAD_YEARS;
          k_nxt     = k_r + K_W'(1);
        end else begin
          k_nxt = '0;
        end
      end
      UOP_I_YR: begin
        more = (k_r < YR_MAX) && (acc_r >= YEAR_DAYS);
        if (more) begin
          acc_nxt   = acc_r - YEAR_DAYS;
          ydate_nxt = ydate_r + ONE_YEAR;
          k_nxt     = k_r + K_W'(1);
        end else begin
          k_nxt = '0;
        end
      end
      UOP_I_MON: begin
        more = (k_r < MON_MAX) && (acc_r >= CNT_W'(mar_month_len(k_r[3:0])));
        if (more) begin
          acc_nxt = acc_r - CNT_W'(mar_month_len(k_r[3:0]));
          k_nxt   = k_r + K_W'(1);
        end
      end
      UOP_I_FIN: begin
        fd_nxt       = acc_r[4:0] + 5'd1;
        fm_nxt       = mm;
        ydate_nxt    = yb_fin;
        rem_nxt      = yb_fin;
        acc_nxt      = '0;
        yok_nxt      = 1'b1;
        range_ok_nxt = (yb_fin >= MIN_YB) && (yb_fin <= MAX_YB);
      end
      UOP_LOAD_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        if (err) begin
          out_nxt.range_error = 1'b1;
        end else begin
          out_nxt.result_day   = fd_r;
          out_nxt.result_month = fm_r;
          out_nxt.result_year  = yout[11:0];
          out_nxt.weekday      = wd_sum[2:0];
          out_nxt.day_distance = (op_r == OP_DIST) ? diff[18:0] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    d1_r       <= d1_nxt;
    m1_r       <= m1_nxt;
    y1_r       <= y1_nxt;
    off_r      <= off_nxt;
    fd_r       <= fd_nxt;
    fm_r       <= fm_nxt;
    ydate_r    <= ydate_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    r400z_r    <= r400z_nxt;
    leap_r     <= leap_nxt;
    yok_r      <= yok_nxt;
    fvalid_r   <= fvalid_nxt;
    c2_r       <= c2_nxt;
    ok2_r      <= ok2_nxt;
    range_ok_r <= range_ok_nxt;
    out_r      <= out_nxt;
  end

  assign out_item         = out_r;
  assign out_valid        = out_valid_r;
  assign status.more      = more;
  assign status.op_dist   = (op_r == OP_DIST);
  assign status.fvalid    = fvalid_r;
  assign status.range_ok  = range_ok_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the Gregorian date shift / distance unit.
// Drives random and boundary dates, predicts each result in SV and compares it field by field.
// Depends on gdsd_pkg, gdsd_chan_if and gregorian_date_shift_and_distance.
module tb_top;
  import gdsd_pkg::*;

  // calendar limits of the block (default parameters)
  localparam int unsigned YEAR_LO    = 1400;
  localparam int unsigned YEAR_HI    = 2400;
  localparam int unsigned EPOCH_BIAS = 4000;     // keeps day counts positive
  localparam int unsigned DAYS_400Y  = 146097;

  localparam int DRAIN_CYCLES   = 300;           // quiet wait after the last result
  localparam int DRAIN_LIMIT    = 20000;
  localparam int HOLD_CYCLES    = 800;           // long receiver hold-off
  localparam int TIMEOUT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  gdsd_chan_if #(.payload_t(in_item_t))  in_chan ();
  gdsd_chan_if #(.payload_t(out_item_t)) out_chan ();

  gregorian_date_shift_and_distance dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // results predicted for accepted items, oldest first
  out_item_t expected_dates[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active = 1'b0;

  int fail_count = 0;
  int n_shift = 0;
  int n_span = 0;
  int n_checked = 0;
  int n_flagged = 0;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic, 32-bit unsigned
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      2:          return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic bit date_ok(input int unsigned d, input int unsigned m,
                                 input int unsigned y);
    if (m < 1 || m > 12) return 1'b0;
    if (y < YEAR_LO || y > YEAR_HI) return 1'b0;
    return d >= 1 && d <= month_length(m, y);
  endfunction

  // March-based linear day count from the biased epoch
  function automatic int unsigned day_count(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned yy, era, yoe, mp, doy, doe;
    yy  = y + EPOCH_BIAS - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_400Y + doe;
  endfunction

  function automatic void count_date(input int unsigned z, output int unsigned d,
                                     output int unsigned m, output int unsigned yb);
    int unsigned era, doe, yoe, doy, mp;
    era = z / DAYS_400Y;
    doe = z - era * DAYS_400Y;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    d   = doy - (153 * mp + 2) / 5 + 1;
    yb  = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // Zeller congruence, rotated so Sunday is 0
  function automatic int unsigned zeller_dow(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned mm, yy, j, k, h;
    mm = m;
    yy = y;
    if (mm < 3) begin
      yy = yy - 1;
      mm = mm + 12;
    end
    j = yy / 100;
    k = yy % 100;
    h = (d + 13 * (mm + 1) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 6) % 7;
  endfunction

  // Expected result for one input transaction
  function automatic out_item_t predict_date_result(input in_item_t it);
    out_item_t   r;
    int unsigned d1, m1, y1, d2, m2, y2, off, c1, c2, c, nd, nm, nyb;
    r = '0;
    r.range_error = 1'b1;
    d1  = it.day;
    m1  = it.month;
    y1  = it.year;
    d2  = it.other_day;
    m2  = it.other_month;
    y2  = it.other_year;
    off = {12'd0, it.offset};
    if (date_ok(d1, m1, y1)) begin
      c1 = day_count(d1, m1, y1);
      if (it.operation == OP_SHIFT) begin
        // negative offsets come in as 20-bit two's complement
        if (off[19]) c = c1 - (32'h100000 - off);
        else         c = c1 + off;
        count_date(c, nd, nm, nyb);
        if (nyb >= EPOCH_BIAS + YEAR_LO && nyb <= EPOCH_BIAS + YEAR_HI) begin
          r.result_day   = nd[4:0];
          r.result_month = nm[3:0];
          r.result_year  = 12'(nyb - EPOCH_BIAS);
          r.weekday      = 3'(zeller_dow(nd, nm, nyb - EPOCH_BIAS));
          r.range_error  = 1'b0;
        end
      end else if (date_ok(d2, m2, y2)) begin
        c2 = day_count(d2, m2, y2);
        r.day_distance = 19'((c1 >= c2) ? c1 - c2 : c2 - c1);
        r.result_day   = it.day;
        r.result_month = it.month;
        r.result_year  = it.year;
        r.weekday      = 3'(zeller_dow(d1, m1, y1));
        r.range_error  = 1'b0;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(input logic op, input int d, input int m, input int y,
                                         input int off, input int od, input int om,
                                         input int oy);
    in_item_t it;
    it.operation   = op;
    it.day         = 5'(d);
    it.month       = 4'(m);
    it.year        = 12'(y);
    it.offset      = 20'(off);
    it.other_day   = 5'(od);
    it.other_month = 4'(om);
    it.other_year  = 12'(oy);
    return it;
  endfunction

  // valid date, biased toward the edge years now and then
  function automatic void pick_date(output int unsigned d, output int unsigned m,
                                    output int unsigned y);
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       y = YEAR_LO;
        1:       y = YEAR_LO + 1;
        2:       y = YEAR_HI - 1;
        default: y = YEAR_HI;
      endcase
    end else begin
      y = $urandom_range(YEAR_HI, YEAR_LO);
    end
    m = $urandom_range(12, 1);
    d = $urandom_range(month_length(m, y), 1);
  endfunction

  function automatic in_item_t random_date_item();
    in_item_t    it;
    int unsigned d, m, y, od, om, oy, pick;
    int          off;
    pick = $urandom_range(99);
    pick_date(d, m, y);
    pick_date(od, om, oy);
    case ($urandom_range(9))
      0, 1, 2, 3: off = int'($urandom_range(6000)) - 3000;
      4, 5, 6:    off = int'($urandom_range(400000)) - 200000;
      default:    off = int'($urandom_range(1048575)) - 524288;
    endcase
    it = make_item(1'($urandom_range(1)), d, m, y, off, od, om, oy);
    if (pick < 10) begin
      // raw noise over every bit of every field
      it = in_item_t'(63'({$urandom, $urandom}));
    end else if (pick < 16) begin
      // well-formed item with one field broken (a day of 31 may still be valid)
      case ($urandom_range(4))
        0: it.day = 5'd0;
        1: it.day = 5'($urandom_range(31, month_length(m, y) + 1 > 31 ? 31 :
                                      month_length(m, y) + 1));
        2: it.month = ($urandom_range(1)) ? 4'd0 : 4'($urandom_range(15, 13));
        3: it.year = ($urandom_range(1)) ? 12'($urandom_range(YEAR_LO - 1))
                                         : 12'($urandom_range(4095, YEAR_HI + 1));
        default: begin
          it.operation  = OP_DIST;
          it.other_year = 12'($urandom_range(4095, YEAR_HI + 1));
        end
      endcase
    end
    return it;
  endfunction

  // One input transaction: optional idle gap, then hold valid until accepted.
  task automatic send_date_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= it;
    do @(posedge clk); while (!in_chan.ready);
    // accepted at this edge
    expected_dates = {expected_dates, predict_date_result(it)};
    if (it.operation == OP_SHIFT) n_shift++;
    else                          n_span++;
  endtask

  // Drop valid, wait for every pending result, then a quiet stretch before the next test.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_chan.valid <= 1'b0;
    while (expected_dates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_dates.size() != 0) begin
      $error("%0d results never arrived", expected_dates.size());
      fail_count++;
      expected_dates.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, long hold-off, field compare
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_date_result(input out_item_t got);
    out_item_t want;
    if (expected_dates.size() == 0) begin
      $error("unexpected result transaction: %p", got);
      fail_count++;
    end else begin
      want = expected_dates.pop_front();
      compare_field("result_day",   want.result_day,   got.result_day);
      compare_field("result_month", want.result_month, got.result_month);
      compare_field("result_year",  want.result_year,  got.result_year);
      compare_field("weekday",      want.weekday,      got.weekday);
      compare_field("day_distance", want.day_distance, got.day_distance);
      compare_field("range_error",  want.range_error,  got.range_error);
      n_checked++;
      if (got.range_error) n_flagged++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_date_result(out_chan.payload);
      if (hold_active) out_chan.ready <= 1'b0;
      else             out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, both operations, leap rules, range edges and invalid dates.
  task automatic test_directed();
    send_date_item(make_item(OP_SHIFT, 1, 1, 1400, 0, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 31, 12, 2400, 0, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 1, 1, 1400, -1, 1, 1, 1400));        // below range
    send_date_item(make_item(OP_SHIFT, 31, 12, 2400, 1, 1, 1, 1400));       // above range
    send_date_item(make_item(OP_SHIFT, 1, 1, 1400, 524287, 1, 1, 1400));    // max offset
    send_date_item(make_item(OP_SHIFT, 31, 12, 2400, -524288, 1, 1, 1400)); // min offset
    send_date_item(make_item(OP_SHIFT, 28, 2, 2000, 1, 1, 1, 1400));        // into Feb 29
    send_date_item(make_item(OP_SHIFT, 28, 2, 1900, 1, 1, 1, 1400));        // century, no leap
    send_date_item(make_item(OP_SHIFT, 29, 2, 2004, 365, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 1, 3, 2000, -1, 1, 1, 1400));
    // other-date fields are don't-care for a shift
    send_date_item(make_item(OP_SHIFT, 15, 6, 1800, 0, 31, 15, 4095));
    send_date_item(make_item(OP_DIST, 1, 1, 1400, 0, 31, 12, 2400));        // widest span
    send_date_item(make_item(OP_DIST, 31, 12, 2400, -1, 1, 1, 1400));
    send_date_item(make_item(OP_DIST, 4, 7, 1776, 0, 4, 7, 1776));          // same dates
    send_date_item(make_item(OP_DIST, 1, 1, 2000, 0, 29, 2, 1900));         // bad second date
    send_date_item(make_item(OP_SHIFT, 0, 1, 2000, 5, 1, 1, 1400));         // day zero
    send_date_item(make_item(OP_SHIFT, 31, 4, 2000, 5, 1, 1, 1400));        // day past month end
    send_date_item(make_item(OP_SHIFT, 29, 2, 1900, 0, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 29, 2, 2000, 0, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 10, 0, 2000, 0, 1, 1, 1400));        // month zero
    send_date_item(make_item(OP_SHIFT, 10, 13, 2000, 0, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 31, 15, 4095, 0, 1, 1, 1400));       // all ones
    send_date_item(make_item(OP_SHIFT, 31, 12, 1399, 0, 1, 1, 1400));
    send_date_item(make_item(OP_SHIFT, 1, 1, 2401, 0, 1, 1, 1400));
    send_date_item(make_item(OP_DIST, 1, 1, 2000, 0, 1, 1, 0));             // second year zero
    drain_results();
  endtask

  // Random traffic under one idle/stall setting.
  task automatic test_random(input int count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_date_item(random_date_item());
    drain_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // transactions, so the output register and the input both back up.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    repeat (20) send_date_item(random_date_item());
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.payload = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(400, 0, 0);
    test_random(350, 53, 0);
    test_random(350, 0, 53);
    test_random(350, 30, 30);
    test_backpressure();

    $display("Covered %0d items: %0d shifts, %0d distances; %0d results checked, %0d with range_error.",
             n_shift + n_span, n_shift, n_span, n_checked, n_flagged);
    $display("Idle mixes: none, sender 53%%, receiver 53%%, both 30%%, plus a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
